// File: hdl/at_response_framer_top_macros.svh
// assertion helpers for the response framer
`ifndef AT_RESPONSE_FRAMER_TOP_MACROS_SVH
`define AT_RESPONSE_FRAMER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define ARF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ARF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/arf_pkg.sv
`timescale 1ns / 1ps
package arf_pkg;

  localparam int BUF_DEPTH  = 2048;
  localparam int ADDR_W     = $clog2(BUF_DEPTH);
  localparam int FILL_W     = ADDR_W;
  localparam logic [FILL_W-1:0] HOLD_MAX = FILL_W'(BUF_DEPTH - 1);
  localparam int TAIL_LEN   = 11;
  localparam int NUM_PREFIX = 6;
  localparam int LEN_W      = 11;
  localparam int IDX_W      = 11;

  localparam logic [7:0] CR = 8'h0D;
  localparam logic [7:0] LF = 8'h0A;

  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_READ    = 2'd1,
    MODE_RELEASE = 2'd2
  } arf_mode_e;

  localparam logic [1:0] DROP_NONE    = 2'd0;
  localparam logic [1:0] DROP_WAITING = 2'd1;
  localparam logic [1:0] DROP_FULL    = 2'd2;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_SEND     = 3'd1;
  localparam logic [2:0] EV_JOIN     = 3'd2;
  localparam logic [2:0] EV_BLE_CONN = 3'd3;
  localparam logic [2:0] EV_BLE_DISC = 3'd4;
  localparam logic [2:0] EV_BLE_IDC  = 3'd5;

  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_OK   = 2'd1;
  localparam logic [1:0] REPLY_ERR  = 2'd2;

  // prefix slots
  localparam int PFX_SEND = 0;
  localparam int PFX_JOIN = 1;
  localparam int PFX_IDC  = 2;
  localparam int PFX_CONN = 3;
  localparam int PFX_DISC = 4;
  localparam int PFX_ERR  = 5;

  localparam logic [7:0] PFX_TEXT [NUM_PREFIX][10] = '{
    '{"+", "S", "E", "N", "D", ":", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"+", "J", "O", "I", "N", ":", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"+", "B", "L", "E", "I", "D", "C", ":", 8'h00, 8'h00},
    '{"+", "B", "L", "E", "C", "O", "N", "N", 8'h0D, 8'h0A},
    '{"+", "B", "L", "E", "D", "I", "S", "C", 8'h0D, 8'h0A},
    '{"E", "R", "R", "O", "R", ":", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] PFX_LEN [NUM_PREFIX] = '{4'd6, 4'd6, 4'd8, 4'd10, 4'd10, 4'd6};

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       rx_byte;
    logic [IDX_W-1:0] read_index;
  } arf_item_t;

  typedef struct packed {
    logic [FILL_W-1:0]            fill;
    logic                         waiting;
    logic [NUM_PREFIX-1:0]        flags;
    logic [TAIL_LEN-1:0][7:0]     tail;   // tail[0] oldest
  } arf_state_t;

  typedef struct packed {
    logic             accepted;
    logic [1:0]       drop_reason;
    logic [2:0]       event_kind;
    logic [1:0]       reply_kind;
    logic [LEN_W-1:0] reply_length;
    logic [7:0]       read_data;
  } arf_result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } arf_wr_t;

endpackage

// File: hdl/arf_line_mem.sv
`timescale 1ns / 1ps
module arf_line_mem import arf_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/arf_step_logic.sv
`timescale 1ns / 1ps
module arf_step_logic import arf_pkg::*; (
  input  arf_item_t   item_i,
  input  arf_state_t  state_i,
  input  logic [7:0]  mem_data_i,
  input  logic        byp_hit_i,
  input  logic [7:0]  byp_data_i,
  output arf_state_t  state_o,
  output arf_result_t result_o,
  output arf_wr_t     wr_o
);

  logic [FILL_W-1:0]        p;
  logic [FILL_W-1:0]        fc1;
  logic [FILL_W-1:0]        fc2;
  logic [NUM_PREFIX-1:0]    flags_n;
  logic [NUM_PREFIX-1:0]    hit;
  logic [TAIL_LEN-1:0][7:0] tail_n;
  logic                     crlf;
  logic [2:0]               ev;
  logic [1:0]               rk;
  logic                     ok_hit;
  logic                     err_hit;

  assign p = state_i.fill;

  always_comb begin
    flags_n = (p == '0) ? '1 : state_i.flags;
    for (int k = 0; k < NUM_PREFIX; k++) begin
      if (p < FILL_W'(PFX_LEN[k]) && item_i.rx_byte != PFX_TEXT[k][p[3:0]]) begin
        flags_n[k] = 1'b0;
      end
    end
  end

  assign tail_n = {item_i.rx_byte, state_i.tail[TAIL_LEN-1:1]};
  assign fc1    = p + FILL_W'(1);
  assign crlf   = tail_n[9] == CR && tail_n[10] == LF;

  always_comb begin
    for (int k = 0; k < NUM_PREFIX; k++) begin
      hit[k] = flags_n[k] && fc1 >= FILL_W'(PFX_LEN[k]);
    end
  end

  // line events take priority over reply detection
  always_comb begin
    ev = EV_NONE;
    if (fc1 > FILL_W'(2) && crlf) begin
      if (hit[PFX_SEND])                            ev = EV_SEND;
      else if (hit[PFX_JOIN])                       ev = EV_JOIN;
      else if (fc1 == FILL_W'(10) && hit[PFX_CONN]) ev = EV_BLE_CONN;
      else if (fc1 == FILL_W'(10) && hit[PFX_DISC]) ev = EV_BLE_DISC;
      else if (hit[PFX_IDC])                        ev = EV_BLE_IDC;
    end
  end

  assign fc2 = (ev != EV_NONE) ? '0 : fc1;

  assign ok_hit =
    (fc2 == FILL_W'(4) && tail_n[10:7] == {LF, CR, 8'("K"), 8'("O")}) ||
    (fc2 >= FILL_W'(6) && tail_n[10:5] == {LF, CR, 8'("K"), 8'("O"), LF, CR});
  assign err_hit = crlf &&
    ((fc2 == FILL_W'(9) && flags_n[PFX_ERR]) ||
     (fc2 >= FILL_W'(11) &&
      tail_n[7:0] == {8'(":"), 8'("R"), 8'("O"), 8'("R"), 8'("R"), 8'("E"), LF, CR}));
  assign rk = ok_hit ? REPLY_OK : (err_hit ? REPLY_ERR : REPLY_NONE);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    wr_o     = '0;
    wr_o.addr = p;
    wr_o.data = item_i.rx_byte;
    unique case (arf_mode_e'(item_i.mode))
      MODE_BYTE: begin
        if (state_i.waiting) begin
          result_o.drop_reason = DROP_WAITING;
        end else if (p >= HOLD_MAX) begin
          result_o.drop_reason = DROP_FULL;
        end else begin
          result_o.accepted   = 1'b1;
          result_o.event_kind = ev;
          result_o.reply_kind = rk;
          wr_o.en       = 1'b1;
          state_o.flags = flags_n;
          state_o.tail  = tail_n;
          // strip the trailing crlf of a finished reply
          state_o.fill  = (rk != REPLY_NONE) ? fc2 - FILL_W'(2) : fc2;
          if (rk != REPLY_NONE) begin
            state_o.waiting = 1'b1;
          end
        end
      end
      MODE_READ: begin
        if (32'(item_i.read_index) < 32'(p)) begin
          result_o.read_data = byp_hit_i ? byp_data_i : mem_data_i;
        end
      end
      MODE_RELEASE: begin
        state_o.waiting = 1'b0;
        state_o.fill    = '0;
      end
      default: begin
      end
    endcase
    result_o.reply_length = LEN_W'(state_o.fill);
  end

endmodule

// File: hdl/at_response_framer_top.sv
`timescale 1ns / 1ps
// channel   direction  tdata (low bit up)                           tuser
// s_axis    in         rx_byte[7:0] read_index[18:8] pad[23:19]     mode[1:0]
// m_axis    out        accepted drop_reason event_kind reply_kind   -
//                      reply_length read_data pad[31:27]
// one result per item, one item per cycle unless the result stage stalls; items pass an input stage and a result stage
// the line buffer read is issued when the item is taken, a bypass covers a store
// committed on that same edge
// reset clears fill count, reply flag, tail window and prefix flags; buffer contents stay
// a stalled result holds the result stage; the input stage still takes one item meanwhile
module at_response_framer_top import arf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // rx_byte, read_index, zero pad
  input  logic [1:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // accepted, drop_reason, event_kind, reply_kind,
                                      // reply_length, read_data, zero pad
);

`include "at_response_framer_top_macros.svh"

  logic        s1_valid_q, s1_valid_d;
  arf_item_t   s1_item_q;
  logic        out_valid_q, out_valid_d;
  arf_result_t out_q;
  arf_state_t  state_q, state_d;
  arf_result_t result;
  arf_wr_t     wr;
  logic        byp_hit_q, byp_hit_d;
  logic [7:0]  byp_data_q;
  logic [7:0]  mem_rdata;
  logic        adv;
  logic        s_acc;
  logic        mem_we;
  logic [ADDR_W-1:0] rd_addr;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign mem_we        = adv && s1_valid_q && wr.en;
  assign rd_addr       = ADDR_W'(s_axis_tdata[18:8]);

  assign s1_valid_d  = s_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = adv ? s1_valid_q : out_valid_q;
  assign byp_hit_d   = mem_we && wr.addr == rd_addr;

  arf_line_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (s_acc),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  arf_step_logic u_step (
    .item_i     (s1_item_q),
    .state_i    (state_q),
    .mem_data_i (mem_rdata),
    .byp_hit_i  (byp_hit_q),
    .byp_data_i (byp_data_q),
    .state_o    (state_d),
    .result_o   (result),
    .wr_o       (wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      byp_hit_q   <= 1'b0;
      state_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s_acc) begin
        byp_hit_q <= byp_hit_d;
      end
      if (adv && s1_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_item_q.mode       <= s_axis_tuser;
      s1_item_q.rx_byte    <= s_axis_tdata[7:0];
      s1_item_q.read_index <= s_axis_tdata[18:8];
      byp_data_q           <= wr.data;
    end
    if (adv && s1_valid_q) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.read_data, out_q.reply_length, out_q.reply_kind,
                          out_q.event_kind, out_q.drop_reason, out_q.accepted};

  `ARF_ASSERT_IMPL(a_fill_bound, 1'b1, state_q.fill <= HOLD_MAX)
  `ARF_ASSERT_IMPL(a_no_store_while_waiting, mem_we, !state_q.waiting)
  `ARF_ASSERT_NEXT(a_stage_hold, s1_valid_q && !adv, s1_valid_q && $stable(s1_item_q))

endmodule

// File: dv/framer_checker.sv
`timescale 1ns / 1ps
module framer_checker import arf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,      // rx_byte, read_index, zero pad
  input  logic [1:0]  s_tuser_i,      // mode
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,      // accepted, drop_reason, event_kind, reply_kind,
                                      // reply_length, read_data, zero pad
  output int          fail_count_o,
  output int          outstanding_o
);

  // shadow copy of the framer state
  logic [7:0]            line_mem [BUF_DEPTH];
  int                    held;
  logic                  reply_held;
  logic [7:0]            tail_q [TAIL_LEN];
  logic [NUM_PREFIX-1:0] match_q;

  arf_result_t framer_result_q [$];
  int          fails;

  initial begin
    fails = 0;
  end

  function automatic bit prefix_hit(int k);
    return match_q[k] && (held >= PFX_LEN[k]);
  endfunction

  function automatic arf_result_t framer_step(logic [1:0] mode, logic [7:0] b,
                                              logic [IDX_W-1:0] idx);
    arf_result_t r;
    int          p;
    bit          crlf;
    bit          ok_hit;
    bit          err_hit;
    r = '0;
    case (mode)
      MODE_BYTE: begin
        if (reply_held) begin
          r.drop_reason = DROP_WAITING;
        end else if (held >= HOLD_MAX) begin
          r.drop_reason = DROP_FULL;
        end else begin
          p = held;
          r.accepted = 1'b1;
          line_mem[p] = b;
          if (p == 0) match_q = '1;
          for (int k = 0; k < NUM_PREFIX; k++) begin
            if (p < PFX_LEN[k] && b != PFX_TEXT[k][p]) match_q[k] = 1'b0;
          end
          for (int i = 0; i < TAIL_LEN - 1; i++) tail_q[i] = tail_q[i+1];
          tail_q[TAIL_LEN-1] = b;
          held = p + 1;
          crlf = (tail_q[9] == CR) && (tail_q[10] == LF);
          if (held > 2 && crlf) begin
            if (prefix_hit(PFX_SEND)) r.event_kind = EV_SEND;
            else if (prefix_hit(PFX_JOIN)) r.event_kind = EV_JOIN;
            else if (held == 10 && prefix_hit(PFX_CONN)) r.event_kind = EV_BLE_CONN;
            else if (held == 10 && prefix_hit(PFX_DISC)) r.event_kind = EV_BLE_DISC;
            else if (prefix_hit(PFX_IDC)) r.event_kind = EV_BLE_IDC;
            if (r.event_kind != EV_NONE) held = 0;
          end
          // the held count keeps both forms within the current line
          ok_hit = crlf && tail_q[7] == "O" && tail_q[8] == "K" &&
                   (held == 4 || (held >= 6 && tail_q[5] == CR && tail_q[6] == LF));
          err_hit = crlf && ((held == 9 && prefix_hit(PFX_ERR)) ||
                    (held >= 11 && tail_q[0] == CR && tail_q[1] == LF &&
                     tail_q[2] == "E" && tail_q[3] == "R" && tail_q[4] == "R" &&
                     tail_q[5] == "O" && tail_q[6] == "R" && tail_q[7] == ":"));
          if (ok_hit) r.reply_kind = REPLY_OK;
          else if (err_hit) r.reply_kind = REPLY_ERR;
          if (r.reply_kind != REPLY_NONE) begin
            held = held - 2;
            reply_held = 1'b1;
          end
        end
      end
      MODE_READ: begin
        if (idx < held) r.read_data = line_mem[idx];
      end
      MODE_RELEASE: begin
        reply_held = 1'b0;
        held = 0;
      end
      default: ;
    endcase
    r.reply_length = LEN_W'(held);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    arf_result_t want;
    if (!rst_ni) begin
      held       = 0;
      reply_held = 1'b0;
      match_q    = '0;
      for (int i = 0; i < TAIL_LEN; i++) tail_q[i] = 8'h00;
      framer_result_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        framer_result_q.push_back(framer_step(s_tuser_i, s_tdata_i[7:0], s_tdata_i[18:8]));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (framer_result_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual %h", $time, m_tdata_i);
          fails++;
        end else begin
          want = framer_result_q.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(m_tdata_i[0]));
          check_field("drop_reason", 32'(want.drop_reason), 32'(m_tdata_i[2:1]));
          check_field("event_kind", 32'(want.event_kind), 32'(m_tdata_i[5:3]));
          check_field("reply_kind", 32'(want.reply_kind), 32'(m_tdata_i[7:6]));
          check_field("reply_length", 32'(want.reply_length), 32'(m_tdata_i[18:8]));
          check_field("read_data", 32'(want.read_data), 32'(m_tdata_i[26:19]));
        end
      end
    end
    fail_count_o  <= fails;
    outstanding_o <= framer_result_q.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import arf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1300;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;

  int fail_count;
  int outstanding;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_cnt = 0;
  int sent = 0;

  arf_item_t plan_q [$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  at_response_framer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  framer_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic plan_item(logic [1:0] mode, logic [7:0] b, logic [IDX_W-1:0] idx);
    arf_item_t it;
    it.mode       = mode;
    it.rx_byte    = b;
    it.read_index = idx;
    plan_q.push_back(it);
  endtask

  task automatic plan_text(string s);
    for (int i = 0; i < s.len(); i++) plan_item(MODE_BYTE, s[i], IDX_W'($urandom_range(2047)));
  endtask

  // mostly printable, now and then any byte
  task automatic plan_body(int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
      plan_item(MODE_BYTE, b, IDX_W'($urandom_range(2047)));
    end
  endtask

  task automatic plan_reads(int n);
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < n; i++) begin
      idx = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(2047)) : IDX_W'($urandom_range(15));
      plan_item(MODE_READ, 8'($urandom_range(255)), idx);
    end
  endtask

  task automatic plan_release();
    plan_item(MODE_RELEASE, 8'($urandom_range(255)), IDX_W'($urandom_range(2047)));
  endtask

  task automatic plan_sequence();
    int    kind;
    int    pick;
    string pfx [5] = '{"+SEND:", "+JOIN:", "+BLEIDC:", "+BLECONN", "+BLEDISC"};
    logic [7:0] sym [8] = '{CR, LF, "O", "K", "E", "R", ":", "+"};
    kind = $urandom_range(99);
    if ($urandom_range(9) != 0) plan_release();
    if (kind < 40) begin
      repeat ($urandom_range(3)) begin
        plan_body($urandom_range(8));
        plan_text("\r\n");
      end
      pick = $urandom_range(5);
      case (pick)
        0, 1: plan_text("OK\r\n");
        2, 3: begin
          plan_text("ERROR:");
          plan_body(1);
          plan_text("\r\n");
        end
        4: plan_text("OK \r\n");
        default: begin
          plan_text("ERROR:");
          plan_body($urandom_range(2) * 2);
          plan_text("\r\n");
        end
      endcase
      plan_reads($urandom_range(4));
      plan_body($urandom_range(2));
      if ($urandom_range(4) != 0) plan_release();
    end else if (kind < 70) begin
      pick = $urandom_range(7);
      case (pick)
        0, 1, 2: begin
          plan_text(pfx[pick]);
          plan_body($urandom_range(6));
          plan_text("\r\n");
        end
        3: plan_text("+BLECONN\r\n");
        4: plan_text("+BLEDISC\r\n");
        5: begin
          // right start, wrong length
          plan_text(pfx[$urandom_range(3, 4)]);
          plan_body($urandom_range(1, 3));
          plan_text("\r\n");
        end
        default: begin
          // line shorter than its prefix
          plan_text(pfx[$urandom_range(4)].substr(0, $urandom_range(0, 4)));
          plan_text("\r\n");
        end
      endcase
      plan_reads($urandom_range(3));
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 12)) begin
        pick = $urandom_range(9);
        plan_item((pick < 6) ? MODE_BYTE : 2'($urandom_range(1, 3)),
                  8'($urandom_range(255)), IDX_W'($urandom_range(2047)));
      end
    end else begin
      repeat ($urandom_range(4, 16)) begin
        if ($urandom_range(4) == 0) plan_body(1);
        else plan_item(MODE_BYTE, sym[$urandom_range(7)], IDX_W'($urandom_range(2047)));
      end
      plan_reads($urandom_range(2));
    end
  endtask

  task automatic send_plan();
    arf_item_t it;
    while (plan_q.size() != 0) begin
      it = plan_q.pop_front();
      while ($urandom_range(99) < idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {5'b0, it.read_index, it.rx_byte};
      s_axis_tuser  <= it.mode;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      sent++;
    end
  endtask

  // drain everything in flight, then move to the next idle and stall mix
  task automatic set_phase(int n);
    int idle_tab [4] = '{0, 78, 0, 14};
    int stall_tab [4] = '{0, 0, 78, 14};
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    idle_pct  = idle_tab[n % 4];
    stall_pct = stall_tab[n % 4];
  endtask

  initial begin : stimulus
    int goal;
    int phase;
    int next_switch;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short reply, drop while waiting, reads at both ends, unused mode, a send event, an error reply
    plan_text("OK\r\n");
    plan_item(MODE_BYTE, 8'hFF, 11'h7FF);
    plan_item(MODE_READ, 8'h00, 11'h000);
    plan_item(MODE_READ, 8'hFF, 11'h7FF);
    plan_item(MODE_UNUSED, 8'hFF, 11'h7FF);
    plan_release();
    plan_text("+SEND:\r\n");
    plan_item(MODE_BYTE, 8'h00, 11'h000);
    plan_item(MODE_READ, 8'h00, 11'h000);
    plan_release();
    plan_text("ERROR:");
    plan_item(MODE_BYTE, 8'h00, 11'h000);
    plan_text("\r\n");
    plan_release();
    send_plan();

    // fill the buffer up to its hold limit, then a full drop and reads at the top
    plan_release();
    for (int i = 0; i < BUF_DEPTH - 2; i++) begin
      plan_item(MODE_BYTE, 8'("a" + $urandom_range(25)), IDX_W'($urandom_range(2047)));
    end
    plan_text("\r\n");
    plan_item(MODE_READ, 8'h00, 11'd2046);
    plan_item(MODE_READ, 8'h00, 11'd2047);
    plan_item(MODE_READ, 8'h00, 11'd0);
    plan_release();
    send_plan();

    goal = sent + RANDOM_ITEMS;
    phase = 0;
    next_switch = sent;
    while (sent < goal) begin
      if (sent >= next_switch) begin
        phase++;
        set_phase(phase);
        next_switch = sent + 130;
      end
      plan_sequence();
      send_plan();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
